// ----- sv/chunked_free_list_slot_allocator_core_macros.svh -----
// Assertion macros shared by the slot allocator modules.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef CHUNKED_FREE_LIST_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define CHUNKED_FREE_LIST_SLOT_ALLOCATOR_CORE_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define CFLA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CFLA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CFLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/cfla_pkg.sv -----
// Shared constants, codes and enum types for the chunked free-list slot allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cfla_pkg;

  localparam int CFG_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam int MAX_SLOTS_DEF = 1024;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] SLOTS_PER_CHUNK_RESET = 11'd16;
  localparam logic [CFG_W-1:0] CHUNK_LIMIT_RESET = 11'd64;

  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_CHUNK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LIMIT = 1'd1;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_REJECTED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_REPORT,
    CMD_POP,
    CMD_PUSH,
    CMD_GROW,
    CMD_REBUILD
  } cmd_kind_t;

endpackage

`default_nettype wire

// ----- sv/chunked_free_list_slot_allocator_core.sv -----
// Top level of the chunked free-list slot allocator: front end, command queue,
// back end and result queue. Depends on cfla_pkg, cfla_fifo, cfla_front and cfla_back.
//
//   Channel     Handshake              Payload
//   input       push / full            operation, slot_index
//   result      pop / empty            status, granted_slot, in_use_count,
//                                      available_count, total_slots
//   config      cfg_write              cfg_index, cfg_data
//
// A free, a rejected or exhausted allocate and an unused code give their result as soon as
// the back end takes them. An allocate from a nonempty list reads the free-list memory first,
// then gives its result. An allocate that grows the pool by more than one slot, and a reset
// of a nonempty pool, write the free slots at one free-list memory write per cycle first.
// The reset input is synchronous and clears all counters; the free-list memory holds no reset.
// The command and result queues hold two items each, so either side can stall on its own.
`default_nettype none

module chunked_free_list_slot_allocator_core
  import cfla_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_data,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [1:0]                   operation,
  input  wire logic [$clog2(MAX_SLOTS)-1:0] slot_index,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [1:0]                        status,
  output logic [$clog2(MAX_SLOTS)-1:0]      granted_slot,
  output logic [$clog2(MAX_SLOTS+1)-1:0]    in_use_count,
  output logic [$clog2(MAX_SLOTS+1)-1:0]    available_count,
  output logic [$clog2(MAX_SLOTS+1)-1:0]    total_slots
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);

  typedef struct packed {
    status_t       status;
    logic [IW-1:0] granted;
    logic [CW-1:0] in_use;
    logic [CW-1:0] available;
    logic [CW-1:0] total;
  } res_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             walk;
    logic [IW-1:0]    addr;
    logic [IW-1:0]    val;
    logic [CW-1:0]    top;
    logic [CFG_W-1:0] chunk;
    res_t             res;
  } cmd_t;

  cmd_t front_cmd;
  cmd_t queued_cmd;
  logic cmd_push;
  logic cmd_empty;
  logic cmd_pop;
  res_t back_res;
  res_t out_res;
  logic res_push;
  logic res_full;

  cfla_front #(
    .MAX_SLOTS(MAX_SLOTS),
    .cmd_t(cmd_t)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .operation(operation),
    .slot_index(slot_index),
    .cmd(front_cmd),
    .cmd_push(cmd_push)
  );

  cfla_fifo #(
    .item_t(cmd_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk(clk),
    .rst(rst),
    .push(cmd_push),
    .item_in(front_cmd),
    .full(full),
    .pop(cmd_pop),
    .item_out(queued_cmd),
    .empty(cmd_empty)
  );

  cfla_back #(
    .MAX_SLOTS(MAX_SLOTS),
    .cmd_t(cmd_t),
    .res_t(res_t)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd(queued_cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop(cmd_pop),
    .res(back_res),
    .res_push(res_push),
    .res_full(res_full)
  );

  cfla_fifo #(
    .item_t(res_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk(clk),
    .rst(rst),
    .push(res_push),
    .item_in(back_res),
    .full(res_full),
    .pop(pop),
    .item_out(out_res),
    .empty(empty)
  );

  assign status = out_res.status;
  assign granted_slot = out_res.granted;
  assign in_use_count = out_res.in_use;
  assign available_count = out_res.available;
  assign total_slots = out_res.total;

endmodule

`default_nettype wire

// ----- sv/cfla_fifo.sv -----
// Small first-in first-out queue of packed items, used between the allocator stages.
// Depends on cfla_pkg for the default depth.
`default_nettype none

module cfla_fifo
  import cfla_pkg::*;
#(
  parameter type item_t = logic,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t item_in,
  output logic       full,
  input  wire logic  pop,
  output item_t      item_out,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  item_t entries [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == NW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign item_out = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/cfla_front.sv -----
// Front end of the allocator: configuration registers, pool counters and operation
// classification into commands for the back end. Depends on cfla_pkg and the macro header.
`default_nettype none
`include "chunked_free_list_slot_allocator_core_macros.svh"

module cfla_front
  import cfla_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter type cmd_t = logic
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_data,
  input  wire logic                         push,
  input  wire logic                         full,
  input  wire logic [1:0]                   operation,
  input  wire logic [$clog2(MAX_SLOTS)-1:0] slot_index,
  output cmd_t                              cmd,
  output logic                              cmd_push
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int WW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  logic [CFG_W-1:0] slots_per_chunk;
  logic [CFG_W-1:0] chunk_limit;
  logic [CW-1:0] stack_depth, stack_depth_next;
  logic [CW-1:0] allocated_slots, allocated_slots_next;
  logic [CW-1:0] capacity_slots, capacity_slots_next;
  logic [CW-1:0] chunks_made, chunks_made_next;
  logic [CFG_W-1:0] chunk_n;
  logic [WW-1:0] grown;
  logic [WW-1:0] rebuild_base;
  logic grow_ok;
  logic free_ok;

  assign cmd_push = push && !full;
  assign chunk_n = (slots_per_chunk == '0) ? CFG_W'(1) : slots_per_chunk;
  assign grown = WW'(capacity_slots) + WW'(chunk_n);
  assign grow_ok = (WW'(chunks_made) < WW'(chunk_limit)) && (grown <= WW'(MAX_SLOTS));
  assign free_ok = (allocated_slots != '0) && (CW'(slot_index) < capacity_slots);
  assign rebuild_base = (WW'(capacity_slots) >= WW'(chunk_n)) ?
                        WW'(capacity_slots) - WW'(chunk_n) : '0;

  always_comb begin
    cmd = '0;
    cmd.kind = CMD_REPORT;
    cmd.chunk = chunk_n;
    cmd.res.status = STATUS_OK;
    stack_depth_next = stack_depth;
    allocated_slots_next = allocated_slots;
    capacity_slots_next = capacity_slots;
    chunks_made_next = chunks_made;
    case (operation)
      OP_ALLOC: begin
        if (stack_depth != '0) begin
          cmd.kind = CMD_POP;
          cmd.addr = IW'(stack_depth - 1'b1);
          stack_depth_next = stack_depth - 1'b1;
          allocated_slots_next = allocated_slots + 1'b1;
        end else if (grow_ok) begin
          cmd.kind = CMD_GROW;
          cmd.walk = (chunk_n != CFG_W'(1));
          cmd.val = IW'(capacity_slots);
          cmd.top = CW'(grown - 1'b1);
          cmd.res.granted = IW'(grown - 1'b1);
          capacity_slots_next = CW'(grown);
          chunks_made_next = chunks_made + 1'b1;
          stack_depth_next = CW'(WW'(chunk_n) - 1'b1);
          allocated_slots_next = allocated_slots + 1'b1;
        end else begin
          cmd.res.status = STATUS_EXHAUSTED;
        end
      end
      OP_FREE: begin
        if (free_ok) begin
          cmd.kind = CMD_PUSH;
          cmd.addr = IW'(stack_depth);
          cmd.val = slot_index;
          stack_depth_next = stack_depth + 1'b1;
          allocated_slots_next = allocated_slots - 1'b1;
        end else begin
          cmd.res.status = STATUS_REJECTED;
        end
      end
      OP_RESET: begin
        cmd.kind = CMD_REBUILD;
        cmd.walk = (capacity_slots != '0);
        cmd.val = IW'(rebuild_base);
        cmd.top = capacity_slots;
        stack_depth_next = capacity_slots;
        allocated_slots_next = '0;
      end
      default: begin
      end
    endcase
    cmd.res.in_use = allocated_slots_next;
    cmd.res.available = stack_depth_next;
    cmd.res.total = capacity_slots_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_per_chunk <= SLOTS_PER_CHUNK_RESET;
      chunk_limit <= CHUNK_LIMIT_RESET;
      stack_depth <= '0;
      allocated_slots <= '0;
      capacity_slots <= '0;
      chunks_made <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SLOTS_PER_CHUNK: slots_per_chunk <= cfg_data;
          REG_CHUNK_LIMIT: chunk_limit <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd_push) begin
        stack_depth <= stack_depth_next;
        allocated_slots <= allocated_slots_next;
        capacity_slots <= capacity_slots_next;
        chunks_made <= chunks_made_next;
      end
    end
  end

  `CFLA_ASSERT_ALWAYS(a_counts_fit, ((CW + 1)'(stack_depth) + (CW + 1)'(allocated_slots) <= (CW + 1)'(capacity_slots)), "free and allocated slots exceed capacity")
  `CFLA_ASSERT_ALWAYS(a_chunks_fit, (chunks_made <= capacity_slots), "more chunks than slots")

endmodule

`default_nettype wire

// ----- sv/cfla_back.sv -----
// Back end of the allocator: the free-list memory, stack pops and pushes, and the
// multi-cycle growth and rebuild walks. Depends on cfla_pkg and the macro header.
`default_nettype none
`include "chunked_free_list_slot_allocator_core_macros.svh"

module cfla_back
  import cfla_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter type cmd_t = logic,
  parameter type res_t = logic
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  output res_t      res,
  output logic      res_push,
  input  wire logic res_full
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int WW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WALK} state_t;

  state_t state;
  cmd_t cur;
  logic [IW-1:0] mem [MAX_SLOTS];
  logic [IW-1:0] rdata;
  logic wen;
  logic [IW-1:0] waddr;
  logic [IW-1:0] wdata;
  logic ren;
  logic [IW-1:0] wpos;
  logic [IW-1:0] wval;
  logic [IW-1:0] gbase;
  logic [CW-1:0] wtop;
  logic [WW-1:0] gbase_next;
  logic group_end;
  logic last_group;
  logic start;

  assign start = (state == S_IDLE) && !cmd_empty && !res_full;
  assign cmd_pop = start;
  assign group_end = ((CW'(wval) + 1'b1) == wtop);
  assign last_group = (gbase == '0);
  assign gbase_next = (WW'(gbase) >= WW'(cur.chunk)) ? WW'(gbase) - WW'(cur.chunk) : '0;
  assign ren = start && (cmd.kind == CMD_POP);

  always_comb begin
    wen = 1'b0;
    waddr = wpos;
    wdata = wval;
    res_push = 1'b0;
    res = cur.res;
    case (state)
      S_IDLE: begin
        res = cmd.res;
        if (start) begin
          case (cmd.kind)
            CMD_PUSH: begin
              wen = 1'b1;
              waddr = cmd.addr;
              wdata = cmd.val;
              res_push = 1'b1;
            end
            CMD_POP: begin
            end
            CMD_GROW, CMD_REBUILD: res_push = !cmd.walk;
            default: res_push = 1'b1;
          endcase
        end
      end
      S_READ: begin
        res.granted = rdata;
        res_push = 1'b1;
      end
      S_WALK: begin
        wen = 1'b1;
        res_push = group_end && last_group;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= cmd;
            wpos <= '0;
            wval <= cmd.val;
            wtop <= cmd.top;
            gbase <= (cmd.kind == CMD_REBUILD) ? cmd.val : '0;
            if (cmd.kind == CMD_POP) begin
              state <= S_READ;
            end else if ((cmd.kind == CMD_GROW || cmd.kind == CMD_REBUILD) && cmd.walk) begin
              state <= S_WALK;
            end
          end
        end
        S_READ: state <= S_IDLE;
        S_WALK: begin
          wpos <= wpos + 1'b1;
          wval <= wval + 1'b1;
          if (group_end) begin
            if (last_group) begin
              state <= S_IDLE;
            end else begin
              wtop <= CW'(gbase);
              wval <= IW'(gbase_next);
              gbase <= IW'(gbase_next);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CFLA_ASSERT_IMPLY(a_result_has_room, res_push, !res_full, "result written into a full queue")
  `CFLA_ASSERT_NEXT(a_read_one_cycle, (state == S_READ), (state == S_IDLE), "pop read did not finish")
  `CFLA_ASSERT_IMPLY(a_walk_in_group, (state == S_WALK), (CW'(wval) < wtop), "walk ran past its group")

endmodule

`default_nettype wire
